>>> sv/agtr2_pkg.sv
package agtr2_pkg;

	localparam int EXP_W         = 12;
	localparam int OUT_FRAC_BITS = 12;
	localparam int DIV_STEPS     = 33;
	localparam int LATENCY       = 8 + DIV_STEPS;

	// m * 2^e with m[31] set; z marks an exact zero
	typedef struct packed {
		logic                    z;
		logic [31:0]             m;
		logic signed [EXP_W-1:0] e;
	} pf_t;

	localparam pf_t INV_PI = '{z: 1'b0, m: 32'hA2F9836E, e: -12'sd33};

	function automatic logic [4:0] lzc17(input logic [16:0] v);
		logic [4:0] cnt;
		cnt = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (v[i]) cnt = 5'(16 - i);
		end
		return cnt;
	endfunction

	function automatic pf_t pf_mul(input pf_t a, input pf_t b);
		logic [63:0] p;
		pf_t r;
		p = 64'(a.m) * 64'(b.m);
		r.z = a.z | b.z;
		if (p[63]) begin
			r.m = p[63:32];
			r.e = a.e + b.e + EXP_W'(32);
		end else begin
			r.m = p[62:31];
			r.e = a.e + b.e + EXP_W'(31);
		end
		return r;
	endfunction

	function automatic pf_t pf_add(input pf_t a, input pf_t b);
		pf_t big;
		pf_t sml;
		pf_t r;
		logic signed [EXP_W:0] diff;
		logic [31:0] aligned;
		logic [32:0] sum;
		if ($signed(a.e) < $signed(b.e)) begin
			big = b;
			sml = a;
		end else begin
			big = a;
			sml = b;
		end
		diff = $signed({big.e[EXP_W-1], big.e}) - $signed({sml.e[EXP_W-1], sml.e});
		aligned = (diff > 31) ? 32'd0 : (sml.m >> diff[4:0]);
		sum = {1'b0, big.m} + {1'b0, aligned};
		r.z = 1'b0;
		if (sum[32]) begin
			r.m = sum[32:1];
			r.e = big.e + EXP_W'(1);
		end else begin
			r.m = sum[31:0];
			r.e = big.e;
		end
		if (a.z) r = b;
		else if (b.z) r = a;
		return r;
	endfunction

endpackage

>>> sv/agtr2_front.sv
module agtr2_front import agtr2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [16:0] min_rough,
	input  logic [15:0] sin_azimuth,
	input  logic [15:0] cos_azimuth,
	input  logic [15:0] sin_polar,
	input  logic [15:0] cos_polar,
	input  logic [16:0] rough_x,
	input  logic [16:0] rough_y,
	output logic        v_s2,
	output pf_t         s2_s2,
	output pf_t         c2_s2,
	output pf_t         sp2_s2,
	output pf_t         cp2_s2,
	output pf_t         ax2_s2,
	output pf_t         ay2_s2,
	output pf_t         p_s2
);

	logic [16:0] lo, rx, ry;
	logic [4:0]  kx, ky;
	logic [15:0] ang [4];
	logic [16:0] mag [4];
	logic [16:0] mn  [4];
	logic [4:0]  mk  [4];

	logic        v_s1;
	pf_t         ax_s1, ay_s1;
	logic [16:0] mn_s1 [4];
	logic [4:0]  k_s1  [4];
	logic        z_s1  [4];

	logic [33:0] sq [4];
	pf_t         sqf [4];

	assign ang[0] = sin_azimuth;
	assign ang[1] = cos_azimuth;
	assign ang[2] = sin_polar;
	assign ang[3] = cos_polar;

	always_comb begin
		lo = (min_rough == 17'd0) ? 17'd1 : min_rough;
		rx = (rough_x < lo) ? lo : rough_x;
		ry = (rough_y < lo) ? lo : rough_y;
		kx = lzc17(rx);
		ky = lzc17(ry);
		for (int i = 0; i < 4; i++) begin
			mag[i] = ang[i][15] ? (17'({1'b0, ~ang[i]}) + 17'd1) : {1'b0, ang[i]};
			mk[i]  = lzc17(mag[i]);
			mn[i]  = mag[i] << mk[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1.z <= 1'b0;
		ax_s1.m <= {rx << kx, 15'd0};
		ax_s1.e <= EXP_W'(-31) - EXP_W'(kx);
		ay_s1.z <= 1'b0;
		ay_s1.m <= {ry << ky, 15'd0};
		ay_s1.e <= EXP_W'(-31) - EXP_W'(ky);
		for (int i = 0; i < 4; i++) begin
			mn_s1[i] <= mn[i];
			k_s1[i]  <= mk[i];
			z_s1[i]  <= (mag[i] == 17'd0);
		end
	end

	// squares are exact: the normalized magnitude always has a zero low bit
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq[i] = 34'(mn_s1[i]) * 34'(mn_s1[i]);
			sqf[i].z = z_s1[i];
			if (sq[i][33]) begin
				sqf[i].m = sq[i][33:2];
				sqf[i].e = EXP_W'(-26) - EXP_W'({k_s1[i], 1'b0});
			end else begin
				sqf[i].m = sq[i][32:1];
				sqf[i].e = EXP_W'(-27) - EXP_W'({k_s1[i], 1'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		s2_s2  <= sqf[0];
		c2_s2  <= sqf[1];
		sp2_s2 <= sqf[2];
		cp2_s2 <= sqf[3];
		ax2_s2 <= pf_mul(ax_s1, ax_s1);
		ay2_s2 <= pf_mul(ay_s1, ay_s1);
		p_s2   <= pf_mul(ax_s1, ay_s1);
	end

endmodule

>>> sv/agtr2_core.sv
module agtr2_core import agtr2_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s2,
	input  pf_t  s2_s2,
	input  pf_t  c2_s2,
	input  pf_t  sp2_s2,
	input  pf_t  cp2_s2,
	input  pf_t  ax2_s2,
	input  pf_t  ay2_s2,
	input  pf_t  p_s2,
	output logic v_s7,
	output pf_t  n_s7,
	output pf_t  dd_s7,
	output logic dz_s7
);

	logic v_s3, v_s4, v_s5, v_s6;
	pf_t  c2ay2_s3, s2ax2_s3, axy2_s3, pp_s3, sp2_s3, cp2_s3, p_s3;
	pf_t  t_s4, cpa_s4, ppp_s4, sp2_s4;
	pf_t  spt_s5, n_s5, cpa_s5;
	pf_t  d_s6, n_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		c2ay2_s3 <= pf_mul(c2_s2, ay2_s2);
		s2ax2_s3 <= pf_mul(s2_s2, ax2_s2);
		axy2_s3  <= pf_mul(ax2_s2, ay2_s2);
		pp_s3    <= pf_mul(p_s2, p_s2);
		sp2_s3   <= sp2_s2;
		cp2_s3   <= cp2_s2;
		p_s3     <= p_s2;

		t_s4   <= pf_add(c2ay2_s3, s2ax2_s3);
		cpa_s4 <= pf_mul(cp2_s3, axy2_s3);
		ppp_s4 <= pf_mul(pp_s3, p_s3);
		sp2_s4 <= sp2_s3;

		spt_s5 <= pf_mul(sp2_s4, t_s4);
		n_s5   <= pf_mul(ppp_s4, INV_PI);
		cpa_s5 <= cpa_s4;

		d_s6 <= pf_add(spt_s5, cpa_s5);
		n_s6 <= n_s5;

		dd_s7 <= pf_mul(d_s6, d_s6);
		dz_s7 <= d_s6.z;
		n_s7  <= n_s6;
	end

endmodule

>>> sv/agtr2_div.sv
module agtr2_div import agtr2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s7,
	input  pf_t         n_s7,
	input  pf_t         dd_s7,
	input  logic        dz_s7,
	output logic        done_q,
	output logic [31:0] density_q,
	output logic        saturated_q
);

	logic                    v_st  [DIV_STEPS+1];
	logic [31:0]             rem_st[DIV_STEPS+1];
	logic [DIV_STEPS-1:0]    quo_st[DIV_STEPS+1];
	logic [31:0]             nb_st [DIV_STEPS+1];
	logic signed [EXP_W-1:0] e_st  [DIV_STEPS+1];
	logic                    dz_st [DIV_STEPS+1];

	assign v_st[0]   = v_s7;
	assign rem_st[0] = n_s7.m;
	assign quo_st[0] = '0;
	assign nb_st[0]  = dd_s7.m;
	assign e_st[0]   = n_s7.e - EXP_W'(32) - dd_s7.e;
	assign dz_st[0]  = dz_s7;

	// one quotient bit per stage; the first step takes the dividend's top word as is
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [32:0] x;
		logic        ge;
		assign x  = (j == 0) ? {1'b0, rem_st[j]} : {rem_st[j], 1'b0};
		assign ge = (x >= {1'b0, nb_st[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[j+1] <= 1'b0;
			end else begin
				v_st[j+1] <= v_st[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_st[j+1] <= ge ? 32'(x - {1'b0, nb_st[j]}) : x[31:0];
			quo_st[j+1] <= {quo_st[j][DIV_STEPS-2:0], ge};
			nb_st[j+1]  <= nb_st[j];
			e_st[j+1]   <= e_st[j];
			dz_st[j+1]  <= dz_st[j];
		end
	end

	logic [DIV_STEPS-1:0]    q;
	logic [31:0]             qm;
	logic signed [EXP_W-1:0] qe;
	logic signed [EXP_W:0]   sh, negsh;
	logic                    sat;
	logic [31:0]             dens;

	always_comb begin
		q = quo_st[DIV_STEPS];
		if (q[DIV_STEPS-1]) begin
			qm = q[DIV_STEPS-1:1];
			qe = e_st[DIV_STEPS] + EXP_W'(1);
		end else begin
			qm = q[31:0];
			qe = e_st[DIV_STEPS];
		end
		sh    = $signed({qe[EXP_W-1], qe}) + $signed((EXP_W+1)'(OUT_FRAC_BITS));
		negsh = -sh;
		sat   = dz_st[DIV_STEPS] || (sh > 0);
		if (sat) dens = '1;
		else if (sh < -31) dens = '0;
		else dens = qm >> negsh[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_st[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		density_q   <= dens;
		saturated_q <= sat;
	end

endmodule

>>> sv/anisotropic_gtr2_ndf.sv
// Anisotropic GGX (GTR2) distribution density, one half vector per word.
// Input: raise start with the six fields; the word is taken at any edge where
// start is high and busy is low. busy stays low: the pipeline takes a new
// word every cycle, so throughput is one word per clock.
// Output: done is high for exactly one cycle with density and saturated;
// there is no backpressure, so the receiver must take the word that cycle.
// From the accepting edge to the result the word passes 7 stages of squares,
// products and sums, 33 stages of the restoring divider (one quotient bit
// per stage), and one output register.
// Configuration: cfg_data is written into min_roughness when cfg_valid is
// high; cfg_ready is always high. Write it only while no word is in flight.
// Reset clears all valid bits and sets min_roughness to 66; words in flight
// are dropped.
module anisotropic_gtr2_ndf import agtr2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] sin_azimuth,
	input  logic [15:0] cos_azimuth,
	input  logic [15:0] sin_polar,
	input  logic [15:0] cos_polar,
	input  logic [16:0] rough_x,
	input  logic [16:0] rough_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	output logic        done,
	output logic [31:0] density,
	output logic        saturated
);

	logic [16:0] min_rough_q;
	logic        v_s2, v_s7, dz_s7;
	pf_t         s2_s2, c2_s2, sp2_s2, cp2_s2, ax2_s2, ay2_s2, p_s2;
	pf_t         n_s7, dd_s7;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rough_q <= 17'd66;
		end else if (cfg_valid && cfg_ready) begin
			min_rough_q <= cfg_data;
		end
	end

	agtr2_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.min_rough   (min_rough_q),
		.sin_azimuth (sin_azimuth),
		.cos_azimuth (cos_azimuth),
		.sin_polar   (sin_polar),
		.cos_polar   (cos_polar),
		.rough_x     (rough_x),
		.rough_y     (rough_y),
		.v_s2        (v_s2),
		.s2_s2       (s2_s2),
		.c2_s2       (c2_s2),
		.sp2_s2      (sp2_s2),
		.cp2_s2      (cp2_s2),
		.ax2_s2      (ax2_s2),
		.ay2_s2      (ay2_s2),
		.p_s2        (p_s2)
	);

	agtr2_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s2   (v_s2),
		.s2_s2  (s2_s2),
		.c2_s2  (c2_s2),
		.sp2_s2 (sp2_s2),
		.cp2_s2 (cp2_s2),
		.ax2_s2 (ax2_s2),
		.ay2_s2 (ay2_s2),
		.p_s2   (p_s2),
		.v_s7   (v_s7),
		.n_s7   (n_s7),
		.dd_s7  (dd_s7),
		.dz_s7  (dz_s7)
	);

	agtr2_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s7        (v_s7),
		.n_s7        (n_s7),
		.dd_s7       (dd_s7),
		.dz_s7       (dz_s7),
		.done_q      (done),
		.density_q   (density),
		.saturated_q (saturated)
	);

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no result");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching input word");

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (density == 32'hFFFF_FFFF))
		else $error("saturated result not at full scale");

endmodule

>>> test/anisotropic_gtr2_ndf_tb.sv
module anisotropic_gtr2_ndf_tb;
	import agtr2_pkg::*;

	localparam int PIPE_DEPTH = LATENCY;

	typedef struct {
		logic [31:0] density;
		logic        saturated;
	} ndf_result_t;

	// software pseudo-float: mantissa 0 or in [2^31, 2^32)
	typedef struct {
		longint unsigned mant;
		int              expo;
	} fp_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] sin_azimuth;
	logic [15:0] cos_azimuth;
	logic [15:0] sin_polar;
	logic [15:0] cos_polar;
	logic [16:0] rough_x;
	logic [16:0] rough_y;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_data;
	logic        done;
	logic [31:0] density;
	logic        saturated;

	ndf_result_t density_q[$];
	logic [16:0] rough_floor;
	int          mismatch_count;
	bit          timed_out;

	anisotropic_gtr2_ndf DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sin_azimuth(sin_azimuth),
		.cos_azimuth(cos_azimuth),
		.sin_polar(sin_polar),
		.cos_polar(cos_polar),
		.rough_x(rough_x),
		.rough_y(rough_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.density(density),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fp_t fp_norm(longint unsigned v, int e);
		fp_t r;
		if (v == 0) begin
			r.mant = 0;
			r.expo = 0;
			return r;
		end
		while (v >= 64'h1_0000_0000) begin
			v = v >> 1;
			e++;
		end
		while (v < 64'h8000_0000) begin
			v = v << 1;
			e--;
		end
		r.mant = v;
		r.expo = e;
		return r;
	endfunction

	function automatic fp_t fp_mul(fp_t a, fp_t b);
		if (a.mant == 0 || b.mant == 0) return fp_norm(0, 0);
		return fp_norm(a.mant * b.mant, a.expo + b.expo);
	endfunction

	function automatic fp_t fp_add(fp_t a, fp_t b);
		fp_t t;
		int diff;
		longint unsigned lesser;
		if (a.mant == 0) return b;
		if (b.mant == 0) return a;
		if (a.expo < b.expo) begin
			t = a;
			a = b;
			b = t;
		end
		diff = a.expo - b.expo;
		lesser = (diff >= 64) ? 0 : (b.mant >> diff);
		return fp_norm(a.mant + lesser, a.expo);
	endfunction

	function automatic fp_t fp_div(fp_t a, fp_t b);
		if (a.mant == 0 || b.mant == 0) return fp_norm(0, 0);
		return fp_norm((a.mant << 32) / b.mant, a.expo - 32 - b.expo);
	endfunction

	function automatic fp_t q14_sq(logic [15:0] raw);
		longint signed v;
		longint unsigned mag;
		v = $signed(raw);
		mag = (v < 0) ? -v : v;
		return fp_norm(mag * mag, -28);
	endfunction

	function automatic ndf_result_t predict_density(logic [15:0] s_az, logic [15:0] c_az,
			logic [15:0] s_po, logic [15:0] c_po, logic [16:0] rx, logic [16:0] ry);
		ndf_result_t r;
		longint unsigned lo, ex, ey;
		fp_t ax, ay, ax2, ay2, tsum, dsum, p, n, q, inv_pi;
		int sh;
		lo = (rough_floor == 0) ? 1 : rough_floor;
		ex = (rx < lo) ? lo : rx;
		ey = (ry < lo) ? lo : ry;
		ax = fp_norm(ex, -16);
		ay = fp_norm(ey, -16);
		ax2 = fp_mul(ax, ax);
		ay2 = fp_mul(ay, ay);
		tsum = fp_add(fp_mul(q14_sq(c_az), ay2), fp_mul(q14_sq(s_az), ax2));
		dsum = fp_add(fp_mul(q14_sq(s_po), tsum), fp_mul(q14_sq(c_po), fp_mul(ax2, ay2)));
		r.density = 32'd0;
		r.saturated = 1'b0;
		if (dsum.mant == 0) begin
			r.saturated = 1'b1;
		end else begin
			inv_pi.mant = 64'hA2F9836E;
			inv_pi.expo = -33;
			p = fp_mul(ax, ay);
			n = fp_mul(fp_mul(fp_mul(p, p), p), inv_pi);
			q = fp_div(n, fp_mul(dsum, dsum));
			if (q.mant != 0) begin
				sh = q.expo + OUT_FRAC_BITS;
				if (sh > 0) r.saturated = 1'b1;
				else if (sh > -64) r.density = 32'(q.mant >> (-sh));
			end
		end
		if (r.saturated) r.density = 32'hFFFF_FFFF;
		return r;
	endfunction

	// compare each output word against the oldest prediction
	always @(posedge clk) begin
		ndf_result_t want;
		if (arst_n && done) begin
			if (density_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: density=%h saturated=%b", density, saturated);
			end else begin
				want = density_q.pop_front();
				if (density !== want.density || saturated !== want.saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected density=%h sat=%b, got density=%h sat=%b",
							want.density, want.saturated, density, saturated);
				end
			end
		end
	end

	task automatic send_word(logic [15:0] s_az, logic [15:0] c_az, logic [15:0] s_po,
			logic [15:0] c_po, logic [16:0] rx, logic [16:0] ry, int gap);
		// drop start while idling so no stale word is taken
		if (gap > 0) start <= 1'b0;
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		sin_azimuth <= s_az;
		cos_azimuth <= c_az;
		sin_polar <= s_po;
		cos_polar <= c_po;
		rough_x <= rx;
		rough_y <= ry;
		@(posedge clk);
		while (busy) @(posedge clk);
		density_q.push_back(predict_density(s_az, c_az, s_po, c_po, rx, ry));
	endtask

	task automatic lower_start();
		start <= 1'b0;
	endtask

	task automatic drain_pipe();
		lower_start();
		while (density_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_floor(logic [16:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rough_floor = value;
		@(posedge clk);
	endtask

	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic logic [15:0] draw_angle();
		case ($urandom_range(0, 5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			3: return 16'($urandom());
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [16:0] draw_rough();
		case ($urandom_range(0, 5))
			0: return 17'($urandom());
			1: return 17'($urandom_range(0, 200));
			2: return 17'd65536;
			default: return 17'($urandom_range(1, 65536));
		endcase
	endfunction

	task automatic test_directed();
		send_word(16'h0000, 16'h4000, 16'h0000, 16'h4000, 17'd65536, 17'd65536, 0);
		send_word(16'h4000, 16'h0000, 16'h4000, 16'h0000, 17'd1, 17'd1, 0);
		// zero denominator: both polar terms zero
		send_word(16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 17'd3000, 17'd9000, 0);
		send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 17'h1FFFF, 17'h1FFFF, 1);
		send_word(16'h7FFF, 16'hC000, 16'h7FFF, 16'hC000, 17'd0, 17'd65536, 0);
		send_word(16'hC000, 16'h0000, 16'h2D41, 16'hD2BF, 17'd66, 17'd65, 2);
		send_word(16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 17'd65536, 17'd1, 0);
		// tiny result: narrow x, wide y, grazing half vector along x
		send_word(16'h0000, 16'h4000, 16'h4000, 16'h0000, 17'd1, 17'h1FFFF, 0);
		send_word(16'h0000, 16'h0000, 16'h4000, 16'h0001, 17'd1, 17'd1, 0);
		send_word(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 17'h10000, 17'h0FFFF, 3);
		drain_pipe();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (draw_gap() != 0 && $urandom_range(0, 1)) begin
				lower_start();
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			send_word(draw_angle(), draw_angle(), draw_angle(), draw_angle(),
				draw_rough(), draw_rough(), 0);
		end
		drain_pipe();
	endtask

	task automatic test_floor_settings();
		write_floor(17'd0);
		test_random(150);
		write_floor(17'd65536);
		test_random(150);
		write_floor(17'h1FFFF);
		test_random(100);
		write_floor(17'd1);
		test_random(200);
		write_floor(17'($urandom_range(1, 20000)));
		test_random(200);
		write_floor(17'd66);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sin_azimuth = '0;
		cos_azimuth = '0;
		sin_polar = '0;
		cos_polar = '0;
		rough_x = '0;
		rough_y = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rough_floor = 17'd66;
		mismatch_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(640);
		test_floor_settings();
		if (mismatch_count == 0 && !timed_out) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		timed_out = 1'b0;
		#2000000;
		timed_out = 1'b1;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
